// ===== rtl/core/xtea_pkg.sv =====
// xtea_pkg: shared constants, types and helper functions of the xtea block cipher
// no dependencies; used by the interfaces, the cells, the key registers and the top level
`timescale 1ns / 1ps

package xtea_pkg;

  // cipher constants
  localparam int unsigned        RoundCountDefault = 32;
  localparam logic [31:0]        Delta             = 32'h9E37_79B9;
  localparam int unsigned        KeyWords          = 4;
  localparam int unsigned        CfgIndexWidth     = 8;

  // register indexes of the key words
  localparam logic [CfgIndexWidth-1:0] RegKeyZero  = 8'd0;
  localparam logic [CfgIndexWidth-1:0] RegKeyOne   = 8'd1;
  localparam logic [CfgIndexWidth-1:0] RegKeyTwo   = 8'd2;
  localparam logic [CfgIndexWidth-1:0] RegKeyThree = 8'd3;

  // key reset values
  localparam logic [31:0] KeyResetZero  = 32'h6C0A_5452;
  localparam logic [31:0] KeyResetOne   = 32'h0382_7D0F;
  localparam logic [31:0] KeyResetTwo   = 32'h3A17_0B92;
  localparam logic [31:0] KeyResetThree = 32'h16DB_7FC2;

  // action codes
  typedef enum logic {
    ActEncrypt = 1'b0,
    ActDecrypt = 1'b1
  } action_e;

  // full key, one word per key index
  typedef logic [KeyWords-1:0][31:0] key_set_t;

  // what travels from one cell to the next
  typedef struct packed {
    action_e     action;
    logic [31:0] v0;
    logic [31:0] v1;
  } blk_data_t;

  // delta times k, modulo 2^32, evaluated at elaboration
  function automatic logic [31:0] delta_times(input int unsigned k);
    logic [63:0] prod;
    prod = 64'(Delta) * 64'(k);
    return prod[31:0];
  endfunction

  // feistel mixing of one word
  function automatic logic [31:0] mix_word(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// ===== rtl/core/xtea_if.sv =====
// xtea_if: valid/ready channel interfaces of the xtea block cipher
// depends on xtea_pkg for the action type and the register index width
`timescale 1ns / 1ps

// block input channel
interface xtea_in_if
  import xtea_pkg::*;
;
  logic        valid;
  logic        ready;
  action_e     action;
  logic [31:0] word_first;
  logic [31:0] word_second;

  modport source (output valid, action, word_first, word_second, input ready);
  modport sink   (input valid, action, word_first, word_second, output ready);
endinterface

// block result channel
interface xtea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_first;
  logic [31:0] result_second;

  modport source (output valid, result_first, result_second, input ready);
  modport sink   (input valid, result_first, result_second, output ready);
endinterface

// configuration write channel
interface xtea_cfg_if
  import xtea_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [31:0]              data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/xtea_key_regs.sv =====
// xtea_key_regs: the four key word registers and their write decode
// depends on xtea_pkg and on the configuration interface in xtea_if.sv
`timescale 1ns / 1ps

module xtea_key_regs
  import xtea_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  xtea_cfg_if.sink    cfg_i,
  output key_set_t    key_o
);

  key_set_t key_q, key_d;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // decode the register index; indexes beyond the list are dropped
  always_comb begin
    key_d = key_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        RegKeyZero:  key_d[0] = cfg_i.data;
        RegKeyOne:   key_d[1] = cfg_i.data;
        RegKeyTwo:   key_d[2] = cfg_i.data;
        RegKeyThree: key_d[3] = cfg_i.data;
        default:     key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= KeyResetZero;
      key_q[1] <= KeyResetOne;
      key_q[2] <= KeyResetTwo;
      key_q[3] <= KeyResetThree;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

// ===== rtl/core/xtea_cell.sv =====
// xtea_cell: one half round of xtea, registered, for either direction
// depends on xtea_pkg; instantiated in a chain by the top level
`timescale 1ns / 1ps

module xtea_cell
  import xtea_pkg::*;
#(
  parameter logic [31:0] EncSum = 32'h0,
  parameter logic [31:0] DecSum = 32'h0,
  parameter bit          Part   = 1'b0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  blk_data_t data_i,
  input  key_set_t  key_i,
  output logic      valid_o,
  output blk_data_t data_o
);

  logic        valid_q;
  blk_data_t   data_q, data_d;
  logic        upd_first;
  logic [31:0] sum;
  logic [1:0]  kidx;
  logic [31:0] src, dst, f, upd;

  // encryption updates the first word in the first half, decryption the second
  assign upd_first = (data_i.action == ActDecrypt) ? Part : !Part;
  assign sum       = (data_i.action == ActDecrypt) ? DecSum : EncSum;
  assign kidx      = upd_first ? sum[1:0] : sum[12:11];
  assign src       = upd_first ? data_i.v1 : data_i.v0;
  assign dst       = upd_first ? data_i.v0 : data_i.v1;
  assign f         = mix_word(src) ^ (sum + key_i[kidx]);
  assign upd       = (data_i.action == ActDecrypt) ? dst - f : dst + f;

  // write back the updated word
  always_comb begin
    data_d        = data_i;
    if (upd_first) begin
      data_d.v0 = upd;
    end else begin
      data_d.v1 = upd;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/xtea_block_cipher.sv =====
// xtea_block_cipher: top level, a chain of half round cells plus an output register
// depends on xtea_pkg, xtea_if.sv, xtea_key_regs and xtea_cell
`timescale 1ns / 1ps

// Usage:
//   blk_in_i   carries action (0 encrypt, 1 decrypt) and the two block words.
//   blk_out_o  returns the two transformed words, one transaction per input.
//   cfg_i      writes key word 0..3 by index; other indexes are ignored.
//              Write only while no block is in flight; cfg_i.ready is always high.
// Throughput: one block per cycle while the output is not stalled. Each of the
//   2*ROUND_COUNT cells performs one half round and passes its result on whenever the chain moves.
// Path: each input block passes through every cell in turn and then through the
//   output register before it appears as a valid result.
// Reset: all cells and the output register are emptied; the key words take
//   their built-in default values.
// Stall: while a result waits in the output register, the chain still moves
//   as long as its last cell is empty; once it is occupied, the chain and the
//   input stop until the result is taken.

module xtea_block_cipher
  import xtea_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = RoundCountDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  xtea_in_if.sink   blk_in_i,
  xtea_out_if.source blk_out_o,
  xtea_cfg_if.sink  cfg_i
);

  localparam int unsigned Stages = 2 * ROUND_COUNT;

  key_set_t    key;
  logic        chain_en;
  logic        out_take;
  logic        valid_s [Stages+1];
  blk_data_t   data_s  [Stages+1];
  logic        out_valid_q;
  logic [31:0] res_first_q, res_second_q;

  // key registers
  xtea_key_regs u_keys (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .key_o  (key)
  );

  // output register may load when empty or being drained
  assign out_take = blk_out_o.ready || !out_valid_q;
  // chain shifts when its last cell can leave or is empty
  assign chain_en = out_take || !valid_s[Stages];

  assign blk_in_i.ready = chain_en;

  // head of the chain
  assign valid_s[0]        = blk_in_i.valid;
  assign data_s[0].action  = blk_in_i.action;
  assign data_s[0].v0      = blk_in_i.word_first;
  assign data_s[0].v1      = blk_in_i.word_second;

  // chain of half round cells
  for (genvar h = 0; h < Stages; h++) begin : g_cell
    localparam int unsigned Rnd = h / 2;
    localparam int unsigned Prt = h % 2;

    xtea_cell #(
      .EncSum (delta_times(Rnd + Prt)),
      .DecSum (delta_times(ROUND_COUNT - Rnd - Prt)),
      .Part   (1'(Prt))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (chain_en),
      .valid_i (valid_s[h]),
      .data_i  (data_s[h]),
      .key_i   (key),
      .valid_o (valid_s[h+1]),
      .data_o  (data_s[h+1])
    );
  end

  // output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= valid_s[Stages];
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_take && valid_s[Stages]) begin
      res_first_q  <= data_s[Stages].v0;
      res_second_q <= data_s[Stages].v1;
    end
  end

  assign blk_out_o.valid         = out_valid_q;
  assign blk_out_o.result_first  = res_first_q;
  assign blk_out_o.result_second = res_second_q;

endmodule

// ===== verif/xtea_tb_pkg.sv =====
// xtea_tb_pkg: scoreboard of the xtea block cipher testbench, with its own cipher predictor
// depends on xtea_pkg for the action type, key word count and register index width
`timescale 1ns / 1ps

package xtea_tb_pkg;
  import xtea_pkg::*;

  localparam int unsigned TbRounds   = 32;
  localparam logic [31:0] TbDelta    = 32'h9E37_79B9;
  localparam logic [31:0] TbKeyReset [KeyWords] = '{
    32'h6C0A_5452, 32'h0382_7D0F, 32'h3A17_0B92, 32'h16DB_7FC2
  };

  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
  } block_words_t;

  class block_scoreboard;
    logic [31:0]  key_word [KeyWords];
    block_words_t pending_blocks [$];
    int unsigned  errors;
    // last prediction, reused by the stimulus for round trips
    block_words_t last_block;
    action_e      last_action;
    bit           have_last;

    function new();
      for (int i = 0; i < KeyWords; i++) key_word[i] = TbKeyReset[i];
      errors    = 0;
      have_last = 1'b0;
    endfunction

    // indexes past the key words are dropped by the block
    function void write_key(logic [CfgIndexWidth-1:0] index, logic [31:0] data);
      if (index < KeyWords) key_word[index[1:0]] = data;
    endfunction

    function logic [31:0] feistel(logic [31:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    function block_words_t encipher(block_words_t blk);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] s;
      block_words_t res;
      a = blk.first;
      b = blk.second;
      s = '0;
      for (int r = 0; r < TbRounds; r++) begin
        a = a + (feistel(b) ^ (s + key_word[s[1:0]]));
        s = s + TbDelta;
        b = b + (feistel(a) ^ (s + key_word[s[12:11]]));
      end
      res.first  = a;
      res.second = b;
      return res;
    endfunction

    function block_words_t decipher(block_words_t blk);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] s;
      block_words_t res;
      a = blk.first;
      b = blk.second;
      s = '0;
      // sum after all rounds, wrapping at 32 bits
      for (int r = 0; r < TbRounds; r++) s = s + TbDelta;
      for (int r = 0; r < TbRounds; r++) begin
        b = b - (feistel(a) ^ (s + key_word[s[12:11]]));
        s = s - TbDelta;
        a = a - (feistel(b) ^ (s + key_word[s[1:0]]));
      end
      res.first  = a;
      res.second = b;
      return res;
    endfunction

    // input transaction accepted: queue its predicted result
    function void note_block(action_e act, logic [31:0] w0, logic [31:0] w1);
      block_words_t blk;
      block_words_t res;
      blk.first  = w0;
      blk.second = w1;
      res = (act == ActEncrypt) ? encipher(blk) : decipher(blk);
      pending_blocks.push_back(res);
      last_block  = res;
      last_action = act;
      have_last   = 1'b1;
    endfunction

    // output transaction accepted: compare with the oldest prediction
    function void check_result(logic [31:0] r0, logic [31:0] r1);
      block_words_t exp_blk;
      if (pending_blocks.size() == 0) begin
        errors++;
        if (errors <= 200)
          $display("%0t: unexpected result, expected none actual %h %h", $time, r0, r1);
        return;
      end
      exp_blk = pending_blocks.pop_front();
      if (r0 !== exp_blk.first) begin
        errors++;
        if (errors <= 200)
          $display("%0t: result_first mismatch, expected %h actual %h",
                   $time, exp_blk.first, r0);
      end
      if (r1 !== exp_blk.second) begin
        errors++;
        if (errors <= 200)
          $display("%0t: result_second mismatch, expected %h actual %h",
                   $time, exp_blk.second, r1);
      end
    endfunction

    function int unsigned outstanding();
      return pending_blocks.size();
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
// tb_top: random and directed test of xtea_block_cipher through its three valid/ready channels
// depends on xtea_pkg, xtea_if.sv, xtea_block_cipher and xtea_tb_pkg
`timescale 1ns / 1ps

module tb_top;
  import xtea_pkg::*;
  import xtea_tb_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PhaseCount   = 7;
  localparam int unsigned ItemsPerPhase = 240;
  localparam int unsigned MaxGap       = 13;

  logic clk_i;
  logic rst_ni;
  int unsigned cycle_count;
  bit src_steady;
  bit snk_steady;

  xtea_in_if  blk_in ();
  xtea_out_if blk_out ();
  xtea_cfg_if cfg ();

  block_scoreboard sb = new();

  xtea_block_cipher uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .blk_in_i  (blk_in),
    .blk_out_o (blk_out),
    .cfg_i     (cfg)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run length guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // per item wait, with steady stretches that have none
  function automatic int unsigned draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic logic [31:0] corner_word();
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return 32'h1 << $urandom_range(0, 31);
    endcase
  endfunction

  // one input transaction; valid stays high afterwards
  task automatic send_block(input action_e act, input logic [31:0] w0, input logic [31:0] w1);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_steady = ~src_steady;
    gap = draw_gap(src_steady);
    if (gap > 0) begin
      blk_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    blk_in.valid       <= 1'b1;
    blk_in.action      <= act;
    blk_in.word_first  <= w0;
    blk_in.word_second <= w1;
    do @(posedge clk_i); while (!blk_in.ready);
    sb.note_block(act, w0, w1);
  endtask

  task automatic send_random();
    action_e     act;
    logic [31:0] w0;
    logic [31:0] w1;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15 && sb.have_last) begin
      // feed the last prediction back the other way
      act = (sb.last_action == ActEncrypt) ? ActDecrypt : ActEncrypt;
      w0  = sb.last_block.first;
      w1  = sb.last_block.second;
    end else if (pick < 25) begin
      act = action_e'($urandom_range(0, 1));
      w0  = corner_word();
      w1  = corner_word();
    end else begin
      act = action_e'($urandom_range(0, 1));
      w0  = $urandom;
      w1  = $urandom;
    end
    send_block(act, w0, w1);
  endtask

  // one configuration transaction, after which valid is driven low
  task automatic write_key(input logic [CfgIndexWidth-1:0] index, input logic [31:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    sb.write_key(index, data);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_keys(input int unsigned phase);
    logic [31:0] keys [KeyWords];
    for (int i = 0; i < KeyWords; i++) begin
      case (phase)
        1: keys[i] = 32'h0000_0000;
        2: keys[i] = 32'hFFFF_FFFF;
        default: keys[i] = $urandom;
      endcase
    end
    if (phase == 3) begin
      keys[RegKeyZero[1:0]]  = 32'h0000_0000;
      keys[RegKeyOne[1:0]]   = 32'hFFFF_FFFF;
      keys[RegKeyTwo[1:0]]   = 32'h8000_0000;
      keys[RegKeyThree[1:0]] = 32'h0000_0001;
    end
    write_key(RegKeyZero,  keys[RegKeyZero[1:0]]);
    write_key(RegKeyOne,   keys[RegKeyOne[1:0]]);
    write_key(RegKeyTwo,   keys[RegKeyTwo[1:0]]);
    write_key(RegKeyThree, keys[RegKeyThree[1:0]]);
    // index past the key words must leave the keys alone
    write_key(CfgIndexWidth'($urandom_range(KeyWords, (1 << CfgIndexWidth) - 1)), $urandom);
  endtask

  // drop valid and let every block in flight come out
  task automatic wait_idle();
    blk_in.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side: random stalls, checks every output transaction
  initial begin
    int unsigned gap;
    blk_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) snk_steady = ~snk_steady;
      gap = draw_gap(snk_steady);
      if (gap > 0) begin
        blk_out.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      blk_out.ready <= 1'b1;
      do @(posedge clk_i); while (!blk_out.valid);
      sb.check_result(blk_out.result_first, blk_out.result_second);
    end
  end

  // stimulus
  initial begin
    cycle_count        = 0;
    src_steady         = 1'b0;
    snk_steady         = 1'b0;
    rst_ni             <= 1'b0;
    blk_in.valid       <= 1'b0;
    blk_in.action      <= ActEncrypt;
    blk_in.word_first  <= '0;
    blk_in.word_second <= '0;
    cfg.valid          <= 1'b0;
    cfg.index          <= '0;
    cfg.data           <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners under the reset key, both directions
    for (int a = 0; a < 2; a++) begin
      send_block(action_e'(a), 32'h0000_0000, 32'h0000_0000);
      send_block(action_e'(a), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(action_e'(a), 32'h0000_0000, 32'hFFFF_FFFF);
      send_block(action_e'(a), 32'hFFFF_FFFF, 32'h0000_0000);
      send_block(action_e'(a), 32'h8000_0000, 32'h0000_0001);
      send_block(action_e'(a), 32'hAAAA_AAAA, 32'h5555_5555);
      send_block(action_e'(a), 32'h0123_4567, 32'h89AB_CDEF);
    end
    // round trip: decrypt what was just encrypted
    send_block(ActEncrypt, 32'hDEAD_BEEF, 32'h0BAD_F00D);
    send_block(ActDecrypt, sb.last_block.first, sb.last_block.second);

    // phases of random traffic, each under its own key
    for (int unsigned p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        wait_idle();
        program_keys(p);
      end
      repeat (ItemsPerPhase) send_random();
    end

    wait_idle();
    repeat (2 * TbRounds + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== xtea_block_cipher.f =====
rtl/core/xtea_pkg.sv
rtl/core/xtea_if.sv
rtl/core/xtea_key_regs.sv
rtl/core/xtea_cell.sv
rtl/core/xtea_block_cipher.sv
verif/xtea_tb_pkg.sv
verif/tb_top.sv
